// ----- design/swls_pkg.sv -----
// types, constants and sizes shared by the local alignment score cells and top level
// no dependencies

package swls_pkg;

    localparam int QUERY_MAX  = 64;
    localparam int TARGET_MAX = 4096;
    localparam int SCORE_BITS = 16;

    localparam int Q_IDX_W  = $clog2(QUERY_MAX);
    localparam int Q_LEN_W  = $clog2(QUERY_MAX + 1);
    localparam int T_POS_W  = $clog2(TARGET_MAX + 1);
    localparam int WIDE_W   = SCORE_BITS + 2;
    localparam int SYM_W    = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [0:0] OP_LOAD_QUERY  = 1'b0;
    localparam logic [0:0] OP_SCORE_TARGET = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAP_EXT  = CFG_IDX_W'(3);

    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic [0:0]       operation;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [SCORE_BITS-1:0] best_score;
        logic [Q_LEN_W-1:0]    best_query_pos;
        logic [T_POS_W-1:0]    best_target_pos;
        logic                  overflow;
    } t_result;

    typedef struct packed {
        logic [3:0]        match_score;
        logic signed [4:0] mismatch_score;
        logic [4:0]        gap;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [SYM_W-1:0]      symbol;
        logic [SCORE_BITS-1:0] diag;
        logic [SCORE_BITS-1:0] up;
        logic [SCORE_BITS-1:0] best_val;
        logic [Q_LEN_W-1:0]    best_row;
        logic [T_POS_W-1:0]    best_col;
        logic [T_POS_W-1:0]    column;
        logic                  last;
    } t_token;

endpackage

// ----- design/swls_cell.sv -----
// one query row of the scoring chain: holds the row symbol and the last column score
// depends on swls_pkg

module swls_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swls_pkg::t_cfg                  i_cfg,
    input  logic [swls_pkg::Q_LEN_W-1:0]    i_row,
    input  logic                            i_active,
    input  logic                            i_we,
    input  logic [swls_pkg::SYM_W-1:0]      i_wsym,
    input  logic                            i_clear,
    input  swls_pkg::t_token                i_tok,
    output swls_pkg::t_token                o_tok
);

    localparam swls_pkg::t_wide CAP = swls_pkg::t_wide'((1 << swls_pkg::SCORE_BITS) - 1);

    logic [swls_pkg::SYM_W-1:0]      r_sym;
    logic [swls_pkg::SCORE_BITS-1:0] r_score;
    logic [swls_pkg::SCORE_BITS-1:0] n_score;
    logic                            r_vld;
    swls_pkg::t_token                r_tok;
    swls_pkg::t_token                n_tok;

    swls_pkg::t_wide w_diag;
    swls_pkg::t_wide w_up;
    swls_pkg::t_wide w_left;
    swls_pkg::t_wide w_gap;
    swls_pkg::t_wide w_sub;
    swls_pkg::t_wide w_cell;
    logic [swls_pkg::SCORE_BITS-1:0] w_cell_s;
    logic w_work;

    always_comb begin
        w_work = i_tok.valid && i_active;
        w_diag = swls_pkg::t_wide'({2'b00, i_tok.diag});
        w_up   = swls_pkg::t_wide'({2'b00, i_tok.up});
        w_left = swls_pkg::t_wide'({2'b00, r_score});
        w_gap  = swls_pkg::t_wide'({{(swls_pkg::WIDE_W-5){1'b0}}, i_cfg.gap});
        if (r_sym == i_tok.symbol) begin
            w_sub = swls_pkg::t_wide'({{(swls_pkg::WIDE_W-4){1'b0}}, i_cfg.match_score});
        end else begin
            w_sub = swls_pkg::t_wide'({{(swls_pkg::WIDE_W-5){i_cfg.mismatch_score[4]}},
                                       i_cfg.mismatch_score});
        end
        w_cell = w_diag + w_sub;
        if (w_up - w_gap > w_cell) begin
            w_cell = w_up - w_gap;
        end
        if (w_left - w_gap > w_cell) begin
            w_cell = w_left - w_gap;
        end
        if (w_cell < 0) begin
            w_cell = '0;
        end
        if (w_cell > CAP) begin
            w_cell = CAP;
        end
        w_cell_s = w_cell[swls_pkg::SCORE_BITS-1:0];

        n_tok = i_tok;
        if (w_work) begin
            n_tok.diag = r_score;
            n_tok.up   = w_cell_s;
            if (w_cell_s > i_tok.best_val ||
                (w_cell_s == i_tok.best_val && i_row < i_tok.best_row)) begin
                n_tok.best_val = w_cell_s;
                n_tok.best_row = i_row;
                n_tok.best_col = i_tok.column;
            end
        end

        if (i_clear) begin
            n_score = '0;
        end else if (w_work) begin
            n_score = w_cell_s;
        end else begin
            n_score = r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_score <= '0;
        end else begin
            r_vld   <= i_tok.valid;
            r_score <= n_score;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (i_we) begin
            r_sym <= i_wsym;
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_vld;
    end

endmodule

// ----- design/smith_waterman_local_score.sv -----
// top level of the local alignment scorer: command port, config registers, cell chain
// depends on swls_pkg and swls_cell
// a target symbol walks the chain of QUERY_MAX cells, one per cycle
// o_done is registered from the chain exit of the last target symbol of a target, busy during the walk
// no new command is accepted while a target symbol walks the cell chain
// synchronous active-low reset clears control state and restores config defaults; query symbols are not cleared

module smith_waterman_local_score (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  swls_pkg::t_cmd                    i_cmd,
    output logic                              o_busy,
    output logic                              o_done,
    output swls_pkg::t_result                 o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swls_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int QM = swls_pkg::QUERY_MAX;

    logic [3:0]        r_match;
    logic signed [4:0] r_mismatch;
    logic [3:0]        r_gap_open;
    logic [3:0]        r_gap_ext;

    logic [swls_pkg::Q_LEN_W-1:0]    r_qlen, n_qlen;
    logic                            r_qdone, n_qdone;
    logic [swls_pkg::T_POS_W-1:0]    r_tpos, n_tpos;
    logic [swls_pkg::SCORE_BITS-1:0] r_best_val, n_best_val;
    logic [swls_pkg::Q_LEN_W-1:0]    r_best_row, n_best_row;
    logic [swls_pkg::T_POS_W-1:0]    r_best_col, n_best_col;
    logic                            r_ovf, n_ovf;
    logic                            r_busy, n_busy;
    logic                            r_done;
    swls_pkg::t_result               r_result, n_result;

    swls_pkg::t_cfg   w_cfg;
    swls_pkg::t_token w_tok [QM+1];
    swls_pkg::t_token w_exit;
    logic [QM-1:0]    w_active;
    logic [QM-1:0]    w_we;
    logic [QM-1:0]    w_tok_vld;
    logic [swls_pkg::Q_LEN_W-1:0] w_base;
    logic w_acc, w_load, w_target, w_clear, w_end;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_result    = r_result;

    assign w_acc    = i_start && !r_busy;
    assign w_load   = w_acc && (i_cmd.operation == swls_pkg::OP_LOAD_QUERY);
    assign w_target = w_acc && (i_cmd.operation == swls_pkg::OP_SCORE_TARGET);
    assign w_exit   = w_tok[QM];
    assign w_end    = w_exit.valid && w_exit.last;
    assign w_base   = r_qdone ? '0 : r_qlen;
    assign w_clear  = w_end || (w_load && r_qdone);

    always_comb begin
        w_cfg.match_score    = r_match;
        w_cfg.mismatch_score = r_mismatch;
        w_cfg.gap            = {1'b0, r_gap_open} + {1'b0, r_gap_ext};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= 4'd2;
            r_mismatch <= -5'sd1;
            r_gap_open <= 4'd1;
            r_gap_ext  <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swls_pkg::REG_MATCH:    r_match    <= i_cfg_data[3:0];
                swls_pkg::REG_MISMATCH: r_mismatch <= signed'(i_cfg_data[4:0]);
                swls_pkg::REG_GAP_OPEN: r_gap_open <= i_cfg_data[3:0];
                swls_pkg::REG_GAP_EXT:  r_gap_ext  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_qlen     = r_qlen;
        n_qdone    = r_qdone;
        n_tpos     = r_tpos;
        n_best_val = r_best_val;
        n_best_row = r_best_row;
        n_best_col = r_best_col;
        n_ovf      = r_ovf;
        n_busy     = r_busy;
        n_result   = r_result;

        if (w_load) begin
            if (r_qdone) begin
                n_tpos     = '0;
                n_best_val = '0;
                n_best_row = '0;
                n_best_col = '0;
                n_ovf      = 1'b0;
            end
            if (w_base < swls_pkg::Q_LEN_W'(QM)) begin
                n_qlen = w_base + swls_pkg::Q_LEN_W'(1);
            end else begin
                n_qlen = w_base;
                n_ovf  = 1'b1;
            end
            n_qdone = i_cmd.last;
        end

        if (w_target) begin
            n_busy = 1'b1;
            if (r_tpos < swls_pkg::T_POS_W'(swls_pkg::TARGET_MAX)) begin
                n_tpos = r_tpos + swls_pkg::T_POS_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (w_exit.valid) begin
            n_busy = 1'b0;
            if (w_exit.last) begin
                n_result.best_score      = w_exit.best_val;
                n_result.best_query_pos  = w_exit.best_row;
                n_result.best_target_pos = w_exit.best_col;
                n_result.overflow        = r_ovf;
                n_tpos     = '0;
                n_best_val = '0;
                n_best_row = '0;
                n_best_col = '0;
                n_ovf      = 1'b0;
            end else begin
                n_best_val = w_exit.best_val;
                n_best_row = w_exit.best_row;
                n_best_col = w_exit.best_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen     <= '0;
            r_qdone    <= 1'b0;
            r_tpos     <= '0;
            r_best_val <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
            r_ovf      <= 1'b0;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_qlen     <= n_qlen;
            r_qdone    <= n_qdone;
            r_tpos     <= n_tpos;
            r_best_val <= n_best_val;
            r_best_row <= n_best_row;
            r_best_col <= n_best_col;
            r_ovf      <= n_ovf;
            r_busy     <= n_busy;
            r_done     <= w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_comb begin
        w_tok[0].valid    = w_target;
        w_tok[0].symbol   = i_cmd.symbol;
        w_tok[0].diag     = '0;
        w_tok[0].up       = '0;
        w_tok[0].best_val = r_best_val;
        w_tok[0].best_row = r_best_row;
        w_tok[0].best_col = r_best_col;
        w_tok[0].column   = n_tpos;
        w_tok[0].last     = i_cmd.last;
    end

    for (genvar g = 0; g < QM; g++) begin : g_cell
        assign w_active[g]  = swls_pkg::Q_LEN_W'(g) < r_qlen;
        assign w_we[g]      = w_load && (w_base == swls_pkg::Q_LEN_W'(g));
        assign w_tok_vld[g] = w_tok[g+1].valid;

        swls_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (w_cfg),
            .i_row    (swls_pkg::Q_LEN_W'(g + 1)),
            .i_active (w_active[g]),
            .i_we     (w_we[g]),
            .i_wsym   (i_cmd.symbol),
            .i_clear  (w_clear),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1])
        );
    end

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vld))
        else $error("more than one token in the cell chain");

    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> r_busy)
        else $error("token left the chain while idle");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(w_end))
        else $error("result strobe without a last target symbol");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_tpos == '0 && r_best_val == '0 && !r_ovf))
        else $error("target state not cleared after result");

    a_qlen_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= swls_pkg::Q_LEN_W'(QM))
        else $error("query length beyond store depth");

endmodule

// ----- tb/smith_waterman_local_score_tb.sv -----
// self-checking testbench for smith_waterman_local_score: command and result transfers
// checked against an in-bench scoring model of the local alignment matrix
// depends on swls_pkg and the smith_waterman_local_score rtl

module smith_waterman_local_score_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swls_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SCORE_CAP   = (1 << SCORE_BITS) - 1;
    localparam int SETTLE_CYCLES = QUERY_MAX + 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_cmd i_cmd = '0;
    logic o_busy;
    logic o_done;
    t_result o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    smith_waterman_local_score DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // scoring model state
    logic [SYM_W-1:0]      qry_sym [QUERY_MAX];
    logic [Q_LEN_W-1:0]    qry_len;
    logic                  qry_done;
    logic [SCORE_BITS-1:0] col_score [QUERY_MAX];
    logic [T_POS_W-1:0]    tgt_pos;
    logic [SCORE_BITS-1:0] top_val;
    logic [Q_LEN_W-1:0]    top_row;
    logic [T_POS_W-1:0]    top_col;
    logic                  ovf_seen;
    logic [3:0]            m_match;
    logic signed [4:0]     m_mis;
    logic [3:0]            g_open;
    logic [3:0]            g_ext;

    t_result expected_alignments [$];
    t_cmd    cmd_backlog [$];
    logic [SYM_W-1:0] alphabet [4];

    bit gaps_on = 1'b1;
    int quiet_cycles = 0;
    int fail_count = 0;
    int n_queued = 0;
    int n_loads = 0;
    int n_targets = 0;
    int n_results = 0;
    int n_reg_writes = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (fail_count < 100)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic clear_alignment();
        for (int r = 0; r < QUERY_MAX; r++)
            col_score[r] = '0;
        tgt_pos  = '0;
        top_val  = '0;
        top_row  = '0;
        top_col  = '0;
        ovf_seen = 1'b0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MATCH: begin
                m_match = val[3:0];
            end
            REG_MISMATCH: begin
                m_mis = signed'(val[4:0]);
            end
            REG_GAP_OPEN: begin
                g_open = val[3:0];
            end
            REG_GAP_EXT: begin
                g_ext = val[3:0];
            end
            default: begin
            end
        endcase
    endtask

    // one column of the matrix per target symbol; a query load extends or restarts the query
    task automatic advance_alignment(input t_cmd c);
        int gap_pen;
        int from_diag;
        int from_up;
        int from_left;
        int score;
        t_result res;
        if (c.operation == OP_LOAD_QUERY) begin
            n_loads++;
            if (qry_done) begin
                qry_len  = '0;
                qry_done = 1'b0;
                clear_alignment();
            end
            if (qry_len < QUERY_MAX) begin
                qry_sym[qry_len] = c.symbol;
                qry_len++;
            end else begin
                ovf_seen = 1'b1;
            end
            if (c.last)
                qry_done = 1'b1;
        end else begin
            n_targets++;
            if (tgt_pos < TARGET_MAX)
                tgt_pos++;
            else
                ovf_seen = 1'b1;
            gap_pen   = int'(g_open) + int'(g_ext);
            from_diag = 0;
            from_up   = 0;
            for (int r = 0; r < int'(qry_len); r++) begin
                from_left = int'(col_score[r]);
                score = from_diag + ((qry_sym[r] == c.symbol) ? int'(m_match) : int'(m_mis));
                if (from_up - gap_pen > score)
                    score = from_up - gap_pen;
                if (from_left - gap_pen > score)
                    score = from_left - gap_pen;
                if (score < 0)
                    score = 0;
                if (score > SCORE_CAP)
                    score = SCORE_CAP;
                from_diag = from_left;
                from_up   = score;
                col_score[r] = SCORE_BITS'(score);
                if (score > int'(top_val) ||
                    (score == int'(top_val) && r + 1 < int'(top_row))) begin
                    top_val = SCORE_BITS'(score);
                    top_row = Q_LEN_W'(r + 1);
                    top_col = tgt_pos;
                end
            end
            if (c.last) begin
                res.best_score      = top_val;
                res.best_query_pos  = top_row;
                res.best_target_pos = top_col;
                res.overflow        = ovf_seen;
                expected_alignments.push_back(res);
                clear_alignment();
            end
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy)
                advance_alignment(i_cmd);
            if (!i_start || !o_busy) begin
                if (cmd_backlog.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 9)) begin
                    i_cmd   <= cmd_backlog.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // result monitor and transfer activity
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_done) begin
                if (expected_alignments.size() == 0) begin
                    flag_mismatch("unexpected result, best_score", o_result.best_score, 0);
                end else begin
                    want = expected_alignments.pop_front();
                    n_results++;
                    if (o_result.best_score !== want.best_score)
                        flag_mismatch("best_score", o_result.best_score, want.best_score);
                    if (o_result.best_query_pos !== want.best_query_pos)
                        flag_mismatch("best_query_pos", o_result.best_query_pos,
                                      want.best_query_pos);
                    if (o_result.best_target_pos !== want.best_target_pos)
                        flag_mismatch("best_target_pos", o_result.best_target_pos,
                                      want.best_target_pos);
                    if (o_result.overflow !== want.overflow)
                        flag_mismatch("overflow", o_result.overflow, want.overflow);
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_register(idx, val);
        n_reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_scoring(input int m, input int mm, input int go, input int ge);
        program_register(REG_MATCH,    {4'($urandom), 4'(m)});
        program_register(REG_MISMATCH, {3'($urandom), 5'(mm)});
        program_register(REG_GAP_OPEN, {4'($urandom), 4'(go)});
        program_register(REG_GAP_EXT,  {4'($urandom), 4'(ge)});
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_start || expected_alignments.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_cmd(input logic [0:0] op, input logic [SYM_W-1:0] sym,
                             input logic lst);
        t_cmd c;
        c.operation = op;
        c.symbol    = sym;
        c.last      = lst;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 3) == 0)
            return SYM_W'($urandom);
        return alphabet[$urandom_range(0, 3)];
    endfunction

    task automatic queue_string(input logic [0:0] op, input int len, input bit mark_last);
        for (int i = 0; i < len; i++)
            queue_cmd(op, pick_symbol(), mark_last && i == len - 1);
    endtask

    function automatic int query_length_pick();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return $urandom_range(QUERY_MAX + 1, QUERY_MAX + 6);
        if (roll < 13)
            return $urandom_range(17, QUERY_MAX);
        return $urandom_range(1, 16);
    endfunction

    task automatic queue_random_traffic(input int n_items);
        int first;
        int roll;
        first = n_queued;
        for (int k = 0; k < 4; k++)
            alphabet[k] = ($urandom_range(0, 5) == 0) ? {SYM_W{k[0]}} : SYM_W'($urandom);
        while (n_queued - first < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                queue_string(OP_LOAD_QUERY, query_length_pick(), 1'b1);
                repeat ($urandom_range(1, 3))
                    queue_string(OP_SCORE_TARGET, $urandom_range(1, 12), 1'b1);
            end else if (roll < 72) begin
                queue_string(OP_SCORE_TARGET, $urandom_range(1, 12), 1'b1);
            end else if (roll < 84) begin
                queue_string(OP_LOAD_QUERY, $urandom_range(1, 6), 1'b0);
                queue_string(OP_SCORE_TARGET, $urandom_range(1, 4), 1'b0);
                queue_string(OP_LOAD_QUERY, $urandom_range(1, 6), 1'b1);
                queue_string(OP_SCORE_TARGET, $urandom_range(1, 6), 1'b1);
            end else if (roll < 94) begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(1'($urandom), SYM_W'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                queue_string(OP_LOAD_QUERY, $urandom_range(1, 10), 1'b1);
            end
        end
    endtask

    initial begin
        qry_len  = '0;
        qry_done = 1'b0;
        clear_alignment();
        m_match = 4'd2;
        m_mis   = -5'sd1;
        g_open  = 4'd1;
        g_ext   = 4'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty query, ties on row and column, target during an open query load
        queue_cmd(OP_SCORE_TARGET, 8'h00, 1'b0);
        queue_cmd(OP_SCORE_TARGET, 8'hFF, 1'b1);
        queue_cmd(OP_LOAD_QUERY,   8'h00, 1'b0);
        queue_cmd(OP_LOAD_QUERY,   8'hFF, 1'b0);
        queue_cmd(OP_LOAD_QUERY,   8'h00, 1'b1);
        queue_cmd(OP_SCORE_TARGET, 8'h00, 1'b0);
        queue_cmd(OP_SCORE_TARGET, 8'h5A, 1'b0);
        queue_cmd(OP_SCORE_TARGET, 8'h00, 1'b1);
        queue_cmd(OP_LOAD_QUERY,   8'h41, 1'b0);
        queue_cmd(OP_LOAD_QUERY,   8'h42, 1'b0);
        queue_cmd(OP_SCORE_TARGET, 8'h42, 1'b0);
        queue_cmd(OP_LOAD_QUERY,   8'h43, 1'b1);
        queue_cmd(OP_SCORE_TARGET, 8'h43, 1'b1);
        queue_cmd(OP_LOAD_QUERY,   8'hA5, 1'b1);
        queue_cmd(OP_SCORE_TARGET, 8'hA5, 1'b1);
        settle();

        set_scoring(15, -16, 0, 0);
        program_register(REG_SPARE_LO, CFG_DATA_W'($urandom));
        queue_random_traffic(60);
        settle();

        set_scoring(0, 15, 15, 15);
        program_register(REG_SPARE_HI, CFG_DATA_W'($urandom));
        queue_random_traffic(60);
        settle();

        gaps_on = 1'b0;
        set_scoring(2, -1, 1, 0);
        queue_random_traffic(60);
        settle();
        gaps_on = 1'b1;

        set_scoring($urandom_range(0, 15), $urandom_range(0, 31) - 16,
                    $urandom_range(0, 3), $urandom_range(0, 3));
        queue_random_traffic(60);
        settle();

        set_scoring($urandom_range(1, 15), $urandom_range(0, 31) - 16,
                    $urandom_range(0, 15), $urandom_range(0, 15));
        queue_random_traffic(60);
        settle();

        // truncated query followed by two targets
        set_scoring(5, -3, 1, 1);
        queue_string(OP_LOAD_QUERY, QUERY_MAX + 4, 1'b1);
        queue_string(OP_SCORE_TARGET, 6, 1'b1);
        queue_string(OP_SCORE_TARGET, 3, 1'b1);
        settle();

        $display("run covered %0d query loads and %0d target symbols under %0d register writes",
                 n_loads, n_targets, n_reg_writes);
        $display("%0d alignment results compared, %0d mismatches", n_results, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
